>>> design/mbce_pkg.sv
`default_nettype none
package mbce_pkg;

  // field widths
  localparam int OFS_W      = 22;
  localparam int COLOUR_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int COL_W      = 7;
  localparam int LW_W       = 11;
  localparam int OX_W       = 10;
  localparam int OY_W       = 10;
  localparam int BPR_W      = 8;
  localparam int ROWS_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 40;
  localparam int PIX_CNT_W  = 3;

  localparam logic [BPR_W-1:0]     MAX_ROW_BYTES = 8'd128;
  localparam logic [PIX_CNT_W-1:0] LAST_PIX      = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_ROWS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR   = 3'd6;

  // reset values
  localparam logic [LW_W-1:0]     RST_LINE_WIDTH    = 11'd320;
  localparam logic [OX_W-1:0]     RST_ORIGIN_X      = 10'd0;
  localparam logic [OY_W-1:0]     RST_ORIGIN_Y      = 10'd0;
  localparam logic [BPR_W-1:0]    RST_BYTES_PER_ROW = 8'd1;
  localparam logic [ROWS_W-1:0]   RST_BITMAP_ROWS   = 11'd8;
  localparam logic [COLOUR_W-1:0] RST_FORE_COLOUR   = 16'hffff;
  localparam logic [COLOUR_W-1:0] RST_BACK_COLOUR   = 16'h0000;

  // settings seen by the datapath, limits already applied
  typedef struct packed {
    logic [OX_W-1:0]     origin_x;
    logic [BPR_W-1:0]    bpr;
    logic [COLOUR_W-1:0] fore;
    logic [COLOUR_W-1:0] back;
    logic [OFS_W-1:0]    start_base;
  } cfg_t;

  // one byte with its address worked out
  typedef struct packed {
    logic [BYTE_W-1:0] bits;
    logic [OFS_W-1:0]  base;
    logic              bmp_end;
  } item_t;

endpackage
`default_nettype wire

>>> design/mono_bitmap_colour_expand_core.sv
`default_nettype none
// monochrome bitmap colour expansion
// input stream: one byte of a 1 bpp bitmap per item, row-major, leftmost
// pixel in bit 7; the block tracks byte column, row and row base itself
// output stream: eight pixel writes per byte, bit 7 first, each with the
// linear frame buffer offset (origin_x + col) + (origin_y + row) * line_width
// (modulo 2^22) and the foreground or background colour
// m_tlast marks the eighth pixel of a byte, m_tuser the last pixel of
// the whole bitmap; the counters then wrap to the top-left corner
// a byte is registered in the address stage and then loaded into the pixel
// serializer; throughput: one pixel per cycle while m_tready is high, set by
// the pixel serializer that feeds the output; a second byte waits in
// the address stage, so the serializer runs without gaps
// when m_tready is low the current pixel holds and s_tready drops once the
// address stage is full
// config: plain write port, one register per cycle; the user must write only
// when idle, the block does not enforce it; line_width, bytes_per_row and
// bitmap_rows of zero read as one, larger values saturate at their limits
// reset: synchronous, clears counters and pipeline, loads register defaults
module mono_bitmap_colour_expand_core #(
  parameter int MAX_LINE_WIDTH  = 1024,
  parameter int MAX_BITMAP_ROWS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mbce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbce_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mbce_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] bitmap_byte
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mbce_pkg::TDATA_W-1:0]          m_tdata,   // [21:0] pixel_offset,
                                                           // [37:22] pixel_colour
  output logic                                  m_tlast,   // last_of_byte
  output logic                                  m_tuser    // end_of_bitmap
);
  import mbce_pkg::*;

  localparam int SW  = ($clog2(MAX_LINE_WIDTH+1) > LW_W) ? $clog2(MAX_LINE_WIDTH+1) : LW_W;
  localparam int RW  = (MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1;
  localparam int RCW = ((RW + 1) > ROWS_W) ? (RW + 1) : ROWS_W;

  cfg_t           cfg;
  logic [SW-1:0]  stride;
  logic [RCW-1:0] rows;
  item_t          item;
  logic           item_valid;
  logic           item_ready;

  // register file, limits and origin row base
  mbce_cfg #(
    .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
    .MAX_BITMAP_ROWS (MAX_BITMAP_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .stride    (stride),
    .rows      (rows)
  );

  // position counters and byte base address
  mbce_addr #(
    .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
    .MAX_BITMAP_ROWS (MAX_BITMAP_ROWS)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stride     (stride),
    .rows       (rows),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_bits     (s_tdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // one pixel per cycle out of the held byte while m_tready is high
  mbce_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  // end of bitmap only on the last pixel of a byte
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("end of bitmap flagged mid byte");

  // pixels of one byte follow without a bubble
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a byte");

  // consecutive pixels of a byte land on consecutive offsets
  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tdata[OFS_W-1:0] == $past(m_tdata[OFS_W-1:0]) + OFS_W'(1))
    else $error("pixel offset did not advance by one");

  // a waiting byte is not dropped while the serializer is busy
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("pending byte lost");

endmodule
`default_nettype wire

>>> design/mbce_cfg.sv
`default_nettype none
module mbce_cfg #(
  parameter int MAX_LINE_WIDTH  = 1024,
  parameter int MAX_BITMAP_ROWS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [mbce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mbce_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mbce_pkg::cfg_t                          cfg,
  output logic [((($clog2(MAX_LINE_WIDTH+1)) > mbce_pkg::LW_W) ?
                 $clog2(MAX_LINE_WIDTH+1) : mbce_pkg::LW_W)-1:0] stride,
  output logic [(((((MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1) + 1) >
                  mbce_pkg::ROWS_W) ?
                 (((MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1) + 1) :
                 mbce_pkg::ROWS_W)-1:0] rows
);
  import mbce_pkg::*;

  localparam int SW  = ($clog2(MAX_LINE_WIDTH+1) > LW_W) ? $clog2(MAX_LINE_WIDTH+1) : LW_W;
  localparam int RW  = (MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1;
  localparam int RCW = ((RW + 1) > ROWS_W) ? (RW + 1) : ROWS_W;
  localparam int PW  = OY_W + SW;

  logic [LW_W-1:0]     line_width, line_width_next;
  logic [OX_W-1:0]     origin_x, origin_x_next;
  logic [OY_W-1:0]     origin_y, origin_y_next;
  logic [BPR_W-1:0]    bytes_per_row, bytes_per_row_next;
  logic [ROWS_W-1:0]   bitmap_rows, bitmap_rows_next;
  logic [COLOUR_W-1:0] fore_colour, fore_colour_next;
  logic [COLOUR_W-1:0] back_colour, back_colour_next;

  logic [SW-1:0]    stride_next;
  logic [RCW-1:0]   rows_next;
  logic [BPR_W-1:0] bpr_next;
  logic [PW-1:0]    prod;

  always_comb begin
    line_width_next    = line_width;
    origin_x_next      = origin_x;
    origin_y_next      = origin_y;
    bytes_per_row_next = bytes_per_row;
    bitmap_rows_next   = bitmap_rows;
    fore_colour_next   = fore_colour;
    back_colour_next   = back_colour;
    if (rst) begin
      line_width_next    = RST_LINE_WIDTH;
      origin_x_next      = RST_ORIGIN_X;
      origin_y_next      = RST_ORIGIN_Y;
      bytes_per_row_next = RST_BYTES_PER_ROW;
      bitmap_rows_next   = RST_BITMAP_ROWS;
      fore_colour_next   = RST_FORE_COLOUR;
      back_colour_next   = RST_BACK_COLOUR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:    line_width_next    = cfg_data[LW_W-1:0];
        REG_ORIGIN_X:      origin_x_next      = cfg_data[OX_W-1:0];
        REG_ORIGIN_Y:      origin_y_next      = cfg_data[OY_W-1:0];
        REG_BYTES_PER_ROW: bytes_per_row_next = cfg_data[BPR_W-1:0];
        REG_BITMAP_ROWS:   bitmap_rows_next   = cfg_data[ROWS_W-1:0];
        REG_FORE_COLOUR:   fore_colour_next   = cfg_data[COLOUR_W-1:0];
        REG_BACK_COLOUR:   back_colour_next   = cfg_data[COLOUR_W-1:0];
        default:           ;
      endcase
    end
  end

  // limits: zero reads as one, large values saturate
  always_comb begin
    if (line_width_next == '0) stride_next = SW'(1);
    else if (SW'(line_width_next) > SW'(MAX_LINE_WIDTH)) stride_next = SW'(MAX_LINE_WIDTH);
    else stride_next = SW'(line_width_next);

    if (bitmap_rows_next == '0) rows_next = RCW'(1);
    else if (RCW'(bitmap_rows_next) > RCW'(MAX_BITMAP_ROWS)) rows_next = RCW'(MAX_BITMAP_ROWS);
    else rows_next = RCW'(bitmap_rows_next);

    if (bytes_per_row_next == '0) bpr_next = BPR_W'(1);
    else if (bytes_per_row_next > MAX_ROW_BYTES) bpr_next = MAX_ROW_BYTES;
    else bpr_next = bytes_per_row_next;

    prod = PW'(origin_y_next) * PW'(stride_next);
  end

  always_ff @(posedge clk) begin
    line_width     <= line_width_next;
    origin_x       <= origin_x_next;
    origin_y       <= origin_y_next;
    bytes_per_row  <= bytes_per_row_next;
    bitmap_rows    <= bitmap_rows_next;
    fore_colour    <= fore_colour_next;
    back_colour    <= back_colour_next;
    stride         <= stride_next;
    rows           <= rows_next;
    cfg.origin_x   <= origin_x_next;
    cfg.bpr        <= bpr_next;
    cfg.fore       <= fore_colour_next;
    cfg.back       <= back_colour_next;
    cfg.start_base <= OFS_W'(prod);
  end

endmodule
`default_nettype wire

>>> design/mbce_addr.sv
`default_nettype none
module mbce_addr #(
  parameter int MAX_LINE_WIDTH  = 1024,
  parameter int MAX_BITMAP_ROWS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mbce_pkg::cfg_t                   cfg,
  input  wire logic [((($clog2(MAX_LINE_WIDTH+1)) > mbce_pkg::LW_W) ?
                      $clog2(MAX_LINE_WIDTH+1) : mbce_pkg::LW_W)-1:0] stride,
  input  wire logic [(((((MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1) + 1) >
                       mbce_pkg::ROWS_W) ?
                      (((MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1) + 1) :
                      mbce_pkg::ROWS_W)-1:0] rows,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mbce_pkg::BYTE_W-1:0]      s_bits,
  output logic                                  item_valid,
  input  wire logic                             item_ready,
  output mbce_pkg::item_t                       item
);
  import mbce_pkg::*;

  localparam int RW  = (MAX_BITMAP_ROWS > 1) ? $clog2(MAX_BITMAP_ROWS) : 1;
  localparam int RCW = ((RW + 1) > ROWS_W) ? (RW + 1) : ROWS_W;

  logic [COL_W-1:0] byte_column, byte_column_next;
  logic [RW-1:0]    row_index, row_index_next;
  logic [OFS_W-1:0] row_base, row_base_next;
  logic [OFS_W-1:0] row_base_cur;
  logic             accept, row_end, bmp_end;

  assign s_tready = !item_valid || item_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    // a bitmap start reloads the row base from the origin
    row_base_cur = (byte_column == '0 && row_index == '0) ? cfg.start_base : row_base;
    row_end      = ({1'b0, byte_column} + BPR_W'(1)) >= cfg.bpr;
    bmp_end      = row_end && ((RCW'(row_index) + RCW'(1)) >= rows);

    byte_column_next = byte_column + COL_W'(1);
    row_index_next   = row_index;
    row_base_next    = row_base_cur;
    if (bmp_end) begin
      byte_column_next = '0;
      row_index_next   = '0;
    end else if (row_end) begin
      byte_column_next = '0;
      row_index_next   = row_index + RW'(1);
      row_base_next    = row_base_cur + OFS_W'(stride);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index   <= '0;
      row_base    <= '0;
      item_valid  <= 1'b0;
    end else begin
      if (accept) begin
        byte_column <= byte_column_next;
        row_index   <= row_index_next;
        row_base    <= row_base_next;
        item_valid  <= 1'b1;
      end else if (item_ready) begin
        item_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.bits    <= s_bits;
      item.base    <= row_base_cur + OFS_W'(cfg.origin_x) + OFS_W'({byte_column, 3'b000});
      item.bmp_end <= bmp_end;
    end
  end

endmodule
`default_nettype wire

>>> design/mbce_serial.sv
`default_nettype none
module mbce_serial (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mbce_pkg::cfg_t                    cfg,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire mbce_pkg::item_t                   item,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [mbce_pkg::TDATA_W-1:0]           m_tdata,
  output logic                                   m_tlast,
  output logic                                   m_tuser
);
  import mbce_pkg::*;

  logic                 busy;
  logic [PIX_CNT_W-1:0] pix_cnt;
  logic [OFS_W-1:0]     offset;
  logic [COLOUR_W-1:0]  colour;
  logic [BYTE_W-2:0]    rest;
  logic                 bmp_end;
  logic                 last;

  assign last       = (pix_cnt == LAST_PIX);
  assign item_ready = !busy || (m_tready && last);

  assign m_tvalid = busy;
  assign m_tdata  = {(TDATA_W - COLOUR_W - OFS_W)'(0), colour, offset};
  assign m_tlast  = last;
  assign m_tuser  = last && bmp_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (item_valid && item_ready) begin
      busy <= 1'b1;
    end else if (busy && m_tready && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      pix_cnt <= '0;
      offset  <= item.base;
      colour  <= item.bits[BYTE_W-1] ? cfg.fore : cfg.back;
      rest    <= item.bits[BYTE_W-2:0];
      bmp_end <= item.bmp_end;
    end else if (busy && m_tready && !last) begin
      pix_cnt <= pix_cnt + PIX_CNT_W'(1);
      offset  <= offset + OFS_W'(1);
      colour  <= rest[BYTE_W-2] ? cfg.fore : cfg.back;
      rest    <= {rest[BYTE_W-3:0], 1'b0};
    end
  end

endmodule
`default_nettype wire
